// ===== design/imrt_pkg.sv =====
package imrt_pkg;

   // default sizes
   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_VALUE_BITS = 8;
   localparam int KEY_BITS       = 32;

   // result status codes
   localparam int STATUS_BITS = 2;
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // item modes
   localparam logic MODE_ASSIGN = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

endpackage

// ===== design/imrt_mem.sv =====
module imrt_mem import imrt_pkg::*; #(
   parameter int DEPTH = DEF_CAPACITY,
   parameter int WIDTH = KEY_BITS + DEF_VALUE_BITS,
   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic [IDX_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/interval_map_range_table_unit.sv =====
// Breakpoint table for range assigns and key lookups. Raise start while busy is low to
// hand over one item; exactly one result comes back on the rsp_ ports, marked by a
// one-cycle rsp_strobe that cannot be held off, so the receiver must take it then.
// Every item but an empty-range assign first scans all n stored breakpoints through
// the table memory's single read port. A lookup then answers. An assign that would
// overflow the table answers with status FULL; one that changes the table moves the
// tail of the table through the same memory, one entry per cycle, and writes at most
// two new breakpoints. An empty range answers from idle with status EMPTY, unscanned.
// default_value is written on the csr_ beat channel, which is always ready, but it
// must only be written while busy is low. The table needs no clearing after reset.
module interval_map_range_table_unit import imrt_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int VALUE_BITS = DEF_VALUE_BITS,
   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_mode,
   input  logic signed [KEY_BITS-1:0] req_first_key,
   input  logic signed [KEY_BITS-1:0] req_end_key,
   input  logic [VALUE_BITS-1:0]      req_new_value,
   output logic                       rsp_strobe,
   output logic [VALUE_BITS-1:0]      rsp_found_value,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [CW-1:0]              rsp_entries_used,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [VALUE_BITS-1:0]      csr_data
);

   localparam int DW = KEY_BITS + VALUE_BITS;
   localparam int SW = CW + 2;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_MOVE, S_INS_B, S_INS_E
   } state_type;

   state_type                 state_ff;
   logic                      rsp_strobe_ff;
   logic [VALUE_BITS-1:0]     rsp_found_ff;
   logic [STATUS_BITS-1:0]    rsp_status_ff;
   logic [CW-1:0]             rsp_used_ff;
   logic [VALUE_BITS-1:0]     dflt_ff;
   logic [CW-1:0]             count_ff;

   logic                      mode_ff;
   logic signed [KEY_BITS-1:0] bkey_ff;
   logic signed [KEY_BITS-1:0] ekey_ff;
   logic [VALUE_BITS-1:0]     nval_ff;

   logic [CW-1:0]             rd_idx_ff;
   logic                      pend_ff;
   logic [IDX_BITS-1:0]       pidx_ff;
   logic [CW-1:0]             nlt_ff;
   logic [CW-1:0]             gt_ff;
   logic [VALUE_BITS-1:0]     vprev_ff;
   logic [VALUE_BITS-1:0]     vend_ff;
   logic [VALUE_BITS-1:0]     vlk_ff;

   logic signed [SW-1:0]      delta_ff;
   logic [CW-1:0]             nnew_ff;
   logic                      ins_b_ff;
   logic                      ins_e_ff;
   logic [IDX_BITS-1:0]       mv_src_ff;
   logic [CW-1:0]             mv_left_ff;
   logic                      mv_up_ff;

   logic [IDX_BITS-1:0]       mem_rd_addr;
   logic [DW-1:0]             mem_rd_data;
   logic                      mem_wr_en;
   logic [IDX_BITS-1:0]       mem_wr_addr;
   logic [DW-1:0]             mem_wr_data;

   logic signed [KEY_BITS-1:0] rd_key;
   logic [VALUE_BITS-1:0]     rd_val;
   logic                      scan_go;
   logic                      ins_b_in;
   logic                      ins_e_in;
   logic [SW-1:0]             nnew_in;
   logic signed [SW-1:0]      delta_in;
   logic [CW-1:0]             tail_in;
   logic signed [SW-1:0]      mv_dst;

   imrt_mem #(.DEPTH(CAPACITY), .WIDTH(DW)) u_mem (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_found_value  = rsp_found_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entries_used = rsp_used_ff;

   assign rd_key  = $signed(mem_rd_data[DW-1:VALUE_BITS]);
   assign rd_val  = mem_rd_data[VALUE_BITS-1:0];
   assign scan_go = (rd_idx_ff < count_ff);

   // decision terms after the scan
   always_comb begin
      ins_b_in = (vprev_ff != nval_ff);
      ins_e_in = (vend_ff != nval_ff);
      nnew_in  = SW'(nlt_ff) + SW'(ins_b_in) + SW'(ins_e_in) + SW'(count_ff) - SW'(gt_ff);
      delta_in = $signed(SW'(nlt_ff) + SW'(ins_b_in) + SW'(ins_e_in)) - $signed(SW'(gt_ff));
      tail_in  = count_ff - gt_ff;
      mv_dst   = $signed(SW'(pidx_ff)) + delta_ff;
   end

   // memory port steering
   always_comb begin
      mem_rd_addr = (state_ff == S_SCAN) ? rd_idx_ff[IDX_BITS-1:0] : mv_src_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = mv_dst[IDX_BITS-1:0];
      mem_wr_data = mem_rd_data;
      unique case (state_ff)
         S_MOVE: begin
            mem_wr_en = pend_ff;
         end
         S_INS_B: begin
            mem_wr_en   = ins_b_ff;
            mem_wr_addr = nlt_ff[IDX_BITS-1:0];
            mem_wr_data = {bkey_ff, nval_ff};
         end
         S_INS_E: begin
            mem_wr_en   = ins_e_ff;
            mem_wr_addr = IDX_BITS'(nlt_ff + CW'(ins_b_ff));
            mem_wr_data = {ekey_ff, vend_ff};
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
         dflt_ff       <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            dflt_ff <= csr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff   <= req_mode;
                  bkey_ff   <= req_first_key;
                  ekey_ff   <= req_end_key;
                  nval_ff   <= req_new_value;
                  rd_idx_ff <= '0;
                  pend_ff   <= 1'b0;
                  nlt_ff    <= '0;
                  gt_ff     <= '0;
                  vprev_ff  <= dflt_ff;
                  vend_ff   <= dflt_ff;
                  vlk_ff    <= dflt_ff;
                  if (req_mode == MODE_ASSIGN && req_first_key >= req_end_key) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_found_ff  <= '0;
                     rsp_status_ff <= STATUS_EMPTY;
                     rsp_used_ff   <= count_ff;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               pend_ff <= scan_go;
               pidx_ff <= rd_idx_ff[IDX_BITS-1:0];
               if (scan_go) begin
                  rd_idx_ff <= rd_idx_ff + 1'b1;
               end
               // sorted keys, so each condition holds on a prefix
               if (pend_ff) begin
                  if (rd_key < bkey_ff) begin
                     nlt_ff   <= CW'(pidx_ff) + 1'b1;
                     vprev_ff <= rd_val;
                  end
                  if (rd_key <= bkey_ff) begin
                     vlk_ff <= rd_val;
                  end
                  if (rd_key <= ekey_ff) begin
                     gt_ff   <= CW'(pidx_ff) + 1'b1;
                     vend_ff <= rd_val;
                  end
               end
               if (!scan_go && !pend_ff) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               ins_b_ff   <= ins_b_in;
               ins_e_ff   <= ins_e_in;
               nnew_ff    <= nnew_in[CW-1:0];
               delta_ff   <= delta_in;
               mv_up_ff   <= (delta_in < 0);
               mv_src_ff  <= (delta_in < 0) ? gt_ff[IDX_BITS-1:0]
                                            : IDX_BITS'(count_ff - 1'b1);
               mv_left_ff <= (delta_in == 0) ? '0 : tail_in;
               pend_ff    <= 1'b0;
               if (mode_ff == MODE_LOOKUP) begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_found_ff  <= vlk_ff;
                  rsp_status_ff <= STATUS_DONE;
                  rsp_used_ff   <= count_ff;
               end else if (nnew_in > SW'(CAPACITY)) begin
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_found_ff  <= '0;
                  rsp_status_ff <= STATUS_FULL;
                  rsp_used_ff   <= count_ff;
               end else begin
                  state_ff <= S_MOVE;
               end
            end
            S_MOVE: begin
               // read one tail entry, write the previous one to its new slot
               pend_ff <= (mv_left_ff != 0);
               pidx_ff <= mv_src_ff;
               if (mv_left_ff != 0) begin
                  mv_left_ff <= mv_left_ff - 1'b1;
                  mv_src_ff  <= mv_up_ff ? mv_src_ff + 1'b1 : mv_src_ff - 1'b1;
               end
               if (mv_left_ff == 0 && !pend_ff) begin
                  state_ff <= S_INS_B;
               end
            end
            S_INS_B: begin
               state_ff <= S_INS_E;
            end
            S_INS_E: begin
               state_ff      <= S_IDLE;
               count_ff      <= nnew_ff;
               rsp_strobe_ff <= 1'b1;
               rsp_found_ff  <= '0;
               rsp_status_ff <= STATUS_DONE;
               rsp_used_ff   <= nnew_ff;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // checks
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("breakpoint count above capacity");

   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_MOVE || state_ff == S_INS_B || state_ff == S_INS_E))
      else $error("table written outside update");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   a_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted item produced nothing");

endmodule
